[rtl/cuc_pkg.sv]
`timescale 1ns / 1ps

package cuc_pkg;

    typedef struct packed {
        logic [11:0] dest_column;
        logic [11:0] dest_row;
    } in_item_t;

    typedef struct packed {
        logic [14:0] source_x;
        logic [14:0] source_y;
        logic        in_range;
    } out_item_t;

    typedef enum logic [3:0] {
        CFG_MATRIX_ROW_X     = 4'd0,
        CFG_MATRIX_ROW_Y     = 4'd1,
        CFG_MATRIX_ROW_DEPTH = 4'd2,
        CFG_CAMERA_OFFSETS   = 4'd3,
        CFG_CYLINDER_RADIUS  = 4'd4,
        CFG_HEIGHT_BASE      = 4'd5,
        CFG_HEIGHT_STEP      = 4'd6,
        CFG_ANGLE_STEP       = 4'd7
    } cfg_index_t;

    // Data that rides alongside the sine and cosine series.
    typedef struct packed {
        logic [30:0] x;
        logic [31:0] x2;
        logic [1:0]  quad;
        logic [29:0] pz;
        logic        dest_ok;
    } side_t;

    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
    localparam logic [30:0] ONE_Q30        = 31'h4000_0000;
    localparam logic [55:0] ROUND_HALF_Q30 = 56'h2000_0000;
    localparam int          HORNER_STEPS   = 6;
    localparam int          RECIP_SHIFT    = 34;
    localparam int          QUOT_W         = 15;

    // Divisors of the Horner steps; lane 0 is the sine series, lane 1 the cosine.
    function automatic logic [7:0] horner_div(input logic lane, input int step);
        logic [7:0] d;
        d = 8'd1;
        case (step)
            0: d = lane ? 8'd182 : 8'd156;
            1: d = lane ? 8'd132 : 8'd110;
            2: d = lane ? 8'd90  : 8'd72;
            3: d = lane ? 8'd56  : 8'd42;
            4: d = lane ? 8'd30  : 8'd20;
            5: d = lane ? 8'd12  : 8'd6;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

endpackage

[rtl/cylinder_unwrap_coordinate_map_unit.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_data  (dest_column, dest_row)
// m_        out        m_valid / m_ready    m_data  (source_x, source_y, in_range)
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction is accepted per cycle. The pipeline holds the phase multiply,
// the six-step Horner series for sine and cosine (three stages a step),
// the projection and a 15-stage restoring divider (one quotient bit a stage).
// Reset clears the stage valid bits and the configuration registers.
// When the output holds a transaction that is not taken, the whole pipeline
// holds and s_ready is low; configuration writes are always taken.

module cylinder_unwrap_coordinate_map_unit #(
    parameter int SRC_WIDTH  = 2048,
    parameter int SRC_HEIGHT = 2048,
    parameter int DEST_SIZE  = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cuc_pkg::in_item_t     s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cuc_pkg::out_item_t    m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [3:0]            cfg_index,
    input  logic [63:0]           cfg_data
);

    localparam int NST = 30 + cuc_pkg::QUOT_W;
    localparam int HS  = cuc_pkg::HORNER_STEPS;
    localparam int HST = 3 * HS;
    localparam int QW  = cuc_pkg::QUOT_W;
    localparam logic [11:0] W_MAX = 12'(SRC_WIDTH - 1);
    localparam logic [11:0] H_MAX = 12'(SRC_HEIGHT - 1);
    localparam logic [12:0] DEST_LIM = 13'(DEST_SIZE);

    // Configuration registers.
    logic [59:0] mrow_reg [3];
    logic [47:0] cam_reg;
    logic [23:0] radius_reg;
    logic [23:0] hbase_reg;
    logic [23:0] hstep_reg;
    logic [23:0] astep_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mrow_reg[0] <= '0;
            mrow_reg[1] <= '0;
            mrow_reg[2] <= '0;
            cam_reg     <= '0;
            radius_reg  <= '0;
            hbase_reg   <= '0;
            hstep_reg   <= '0;
            astep_reg   <= '0;
        end else if (cfg_valid) begin
            case (cuc_pkg::cfg_index_t'(cfg_index))
                cuc_pkg::CFG_MATRIX_ROW_X:     mrow_reg[0] <= cfg_data[59:0];
                cuc_pkg::CFG_MATRIX_ROW_Y:     mrow_reg[1] <= cfg_data[59:0];
                cuc_pkg::CFG_MATRIX_ROW_DEPTH: mrow_reg[2] <= cfg_data[59:0];
                cuc_pkg::CFG_CAMERA_OFFSETS:   cam_reg     <= cfg_data[47:0];
                cuc_pkg::CFG_CYLINDER_RADIUS:  radius_reg  <= cfg_data[23:0];
                cuc_pkg::CFG_HEIGHT_BASE:      hbase_reg   <= cfg_data[23:0];
                cuc_pkg::CFG_HEIGHT_STEP:      hstep_reg   <= cfg_data[23:0];
                cuc_pkg::CFG_ANGLE_STEP:       astep_reg   <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Stage valid bits and the common advance.
    logic [NST-1:0] vld_reg;
    logic           en;

    assign en      = !vld_reg[NST-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    // Stage 1: angle and height products.
    logic [35:0] theta1_reg, hrow1_reg;
    logic        dok1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            theta1_reg <= 36'(s_data.dest_column) * 36'(astep_reg);
            hrow1_reg  <= 36'(s_data.dest_row) * 36'(hstep_reg);
            dok1_reg   <= (13'(s_data.dest_column) < DEST_LIM) &&
                          (13'(s_data.dest_row) < DEST_LIM);
        end
    end

    // Stage 2: angle to turns, split in two partial products; height sum.
    logic [47:0] pplo2_reg, pphi2_reg;
    logic [29:0] pz2_reg;
    logic        dok2_reg;
    logic [36:0] hround_next;

    assign hround_next = 37'(hrow1_reg) + 37'd128;

    always_ff @(posedge aclk) begin
        if (en) begin
            pplo2_reg <= 48'(theta1_reg[17:0]) * 48'(cuc_pkg::INV_TWO_PI_Q32);
            pphi2_reg <= 48'(theta1_reg[35:18]) * 48'(cuc_pkg::INV_TWO_PI_Q32);
            pz2_reg   <= 30'(hbase_reg) + 30'(hround_next >> 8);
            dok2_reg  <= dok1_reg;
        end
    end

    // Stage 3: phase in turns.
    logic [19:0] ph3_reg;
    logic [29:0] pz3_reg;
    logic        dok3_reg;
    logic [55:0] phsum_next;

    assign phsum_next = 56'(pplo2_reg) + (56'(pphi2_reg) << 18);

    always_ff @(posedge aclk) begin
        if (en) begin
            ph3_reg  <= phsum_next[55:36];
            pz3_reg  <= pz2_reg;
            dok3_reg <= dok2_reg;
        end
    end

    // Stage 4: angle inside the quadrant in Q30 radians.
    logic [30:0] x4_reg;
    logic [1:0]  quad4_reg;
    logic [29:0] pz4_reg;
    logic        dok4_reg;
    logic [48:0] xprod_next;

    assign xprod_next = 49'(ph3_reg[17:0]) * 49'(cuc_pkg::HALF_PI_Q30);

    always_ff @(posedge aclk) begin
        if (en) begin
            x4_reg    <= xprod_next[48:18];
            quad4_reg <= ph3_reg[19:18];
            pz4_reg   <= pz3_reg;
            dok4_reg  <= dok3_reg;
        end
    end

    // Stage 5: x squared.
    cuc_pkg::side_t side5_reg;
    logic [61:0]    xsq_next;

    assign xsq_next = 62'(x4_reg) * 62'(x4_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            side5_reg.x       <= x4_reg;
            side5_reg.x2      <= xsq_next[61:30];
            side5_reg.quad    <= quad4_reg;
            side5_reg.pz      <= pz4_reg;
            side5_reg.dest_ok <= dok4_reg;
        end
    end

    // Horner series: each step is a multiply, a reciprocal multiply, and a
    // correction with the subtract from one.
    cuc_pkg::side_t side_reg [HST];
    cuc_pkg::side_t side_in  [HST];

    assign side_in[0] = side5_reg;
    for (genvar j = 1; j < HST; j++) begin : g_side_in
        assign side_in[j] = side_reg[j-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < HST; j++) begin
                side_reg[j] <= side_in[j];
            end
        end
    end

    logic [31:0] hy_reg  [2][HS];
    logic [31:0] hyb_reg [2][HS];
    logic [29:0] hq0_reg [2][HS];
    logic [30:0] ht_reg  [2][HS];

    for (genvar l = 0; l < 2; l++) begin : g_lane
        for (genvar k = 0; k < HS; k++) begin : g_step
            localparam logic [7:0]  D  = cuc_pkg::horner_div(l == 1, k);
            localparam logic [31:0] RM = 32'((64'd1 << cuc_pkg::RECIP_SHIFT) / D);
            logic [30:0] t_in;
            logic [62:0] ya_next;
            logic [63:0] qb_next;
            logic [37:0] qd_next;
            logic [31:0] rem_next;
            logic [30:0] qc_next;

            if (k == 0) begin : g_first
                assign t_in = cuc_pkg::ONE_Q30;
            end else begin : g_chain
                assign t_in = ht_reg[l][k-1];
            end

            assign ya_next  = 63'(side_in[3*k].x2) * 63'(t_in);
            assign qb_next  = 64'(hy_reg[l][k]) * 64'(RM);
            assign qd_next  = 38'(hq0_reg[l][k]) * 38'(D);
            assign rem_next = hyb_reg[l][k] - qd_next[31:0];
            // The reciprocal estimate is low by at most one.
            assign qc_next  = 31'(hq0_reg[l][k]) + ((rem_next >= 32'(D)) ? 31'd1 : 31'd0);

            always_ff @(posedge aclk) begin
                if (en) begin
                    hy_reg[l][k]  <= ya_next[61:30];
                    hq0_reg[l][k] <= qb_next[63:34];
                    hyb_reg[l][k] <= hy_reg[l][k];
                    ht_reg[l][k]  <= cuc_pkg::ONE_Q30 - qc_next;
                end
            end
        end
    end

    // Stage 24: final sine product and cosine square term.
    logic [31:0] sraw_reg, yc_reg;
    logic [1:0]  quad24_reg;
    logic [29:0] pz24_reg;
    logic        dok24_reg;
    logic [61:0] sprod_next;
    logic [62:0] cprod_next;

    assign sprod_next = 62'(side_reg[HST-1].x) * 62'(ht_reg[0][HS-1]);
    assign cprod_next = 63'(side_reg[HST-1].x2) * 63'(ht_reg[1][HS-1]);

    always_ff @(posedge aclk) begin
        if (en) begin
            sraw_reg   <= sprod_next[61:30];
            yc_reg     <= cprod_next[61:30];
            quad24_reg <= side_reg[HST-1].quad;
            pz24_reg   <= side_reg[HST-1].pz;
            dok24_reg  <= side_reg[HST-1].dest_ok;
        end
    end

    // Stage 25: clamp cosine and rotate to the quadrant as sign and magnitude.
    logic [30:0] magc_reg, mags_reg;
    logic        negc_reg, negs_reg;
    logic [29:0] pz25_reg;
    logic        dok25_reg;
    logic [30:0] chalf_next, cval_next, sval_next;
    logic        swap_next;

    assign chalf_next = yc_reg[31:1];
    assign cval_next  = (chalf_next > cuc_pkg::ONE_Q30) ? 31'd0 :
                        cuc_pkg::ONE_Q30 - chalf_next;
    assign sval_next  = sraw_reg[30:0];
    assign swap_next  = quad24_reg[0];

    always_ff @(posedge aclk) begin
        if (en) begin
            magc_reg  <= swap_next ? sval_next : cval_next;
            mags_reg  <= swap_next ? cval_next : sval_next;
            negc_reg  <= quad24_reg[0] ^ quad24_reg[1];
            negs_reg  <= quad24_reg[1];
            pz25_reg  <= pz24_reg;
            dok25_reg <= dok24_reg;
        end
    end

    // Stage 26: radius products.
    logic [54:0] rprodc_reg, rprods_reg;
    logic        rnegc_reg, rnegs_reg;
    logic [29:0] pz26_reg;
    logic        dok26_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rprodc_reg <= 55'(radius_reg) * 55'(magc_reg);
            rprods_reg <= 55'(radius_reg) * 55'(mags_reg);
            rnegc_reg  <= negc_reg;
            rnegs_reg  <= negs_reg;
            pz26_reg   <= pz25_reg;
            dok26_reg  <= dok25_reg;
        end
    end

    // Stage 27: round the radius terms and add the camera offsets.
    logic signed [26:0] px_reg, py_reg;
    logic signed [30:0] pz_reg;
    logic               dok27_reg;
    logic [55:0]        rndc_next, rnds_next;
    logic signed [26:0] pc_next, ps_next;

    assign rndc_next = 56'(rprodc_reg) + cuc_pkg::ROUND_HALF_Q30;
    assign rnds_next = 56'(rprods_reg) + cuc_pkg::ROUND_HALF_Q30;
    assign pc_next   = $signed({1'b0, rndc_next[55:30]});
    assign ps_next   = $signed({1'b0, rnds_next[55:30]});

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg    <= 27'($signed(cam_reg[23:0])) + (rnegc_reg ? -pc_next : pc_next);
            py_reg    <= 27'($signed(cam_reg[47:24])) + (rnegs_reg ? -ps_next : ps_next);
            pz_reg    <= $signed({1'b0, pz26_reg});
            dok27_reg <= dok26_reg;
        end
    end

    // Stage 28: the nine matrix products.
    logic signed [50:0] pp_reg  [3][3];
    logic signed [50:0] pp_next [3][3];
    logic signed [50:0] opnd_next [3];
    logic               dok28_reg;

    always_comb begin
        opnd_next[0] = 51'(px_reg);
        opnd_next[1] = 51'(py_reg);
        opnd_next[2] = 51'(pz_reg);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                pp_next[r][c] = opnd_next[c] * 51'($signed(mrow_reg[r][20*c +: 20]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_reg    <= pp_next;
            dok28_reg <= dok27_reg;
        end
    end

    // Stage 29: dot products (row 0 is x, row 1 is y, row 2 is depth).
    logic signed [53:0] dot_reg [3];
    logic               dok29_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                dot_reg[r] <= 54'(pp_reg[r][0]) + 54'(pp_reg[r][1]) + 54'(pp_reg[r][2]);
            end
            dok29_reg <= dok28_reg;
        end
    end

    // Stage 30: range checks; an invalid point divides zero by one.
    logic [56:0] numx_reg, numy_reg;
    logic [52:0] den_reg;
    logic        ok_reg;
    logic [64:0] limx_next, limy_next;
    logic        ok_next;

    assign limx_next = 65'(dot_reg[2][52:0]) * 65'(W_MAX);
    assign limy_next = 65'(dot_reg[2][52:0]) * 65'(H_MAX);
    assign ok_next   = dok29_reg && !dot_reg[2][53] && (dot_reg[2] != '0) &&
                       !dot_reg[0][53] && !dot_reg[1][53] &&
                       (65'(dot_reg[0][52:0]) <= limx_next) &&
                       (65'(dot_reg[1][52:0]) <= limy_next);

    always_ff @(posedge aclk) begin
        if (en) begin
            numx_reg <= ok_next ? {dot_reg[0][52:0], 4'b0000} : '0;
            numy_reg <= ok_next ? {dot_reg[1][52:0], 4'b0000} : '0;
            den_reg  <= ok_next ? dot_reg[2][52:0] : 53'd1;
            ok_reg   <= ok_next;
        end
    end

    // Restoring divider, one quotient bit per stage, most significant first.
    logic [56:0] drx_reg [QW];
    logic [56:0] dry_reg [QW];
    logic [14:0] dqx_reg [QW];
    logic [14:0] dqy_reg [QW];
    logic [52:0] dden_reg [QW];
    logic        dok_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_div
        localparam int B = QW - 1 - i;
        logic [56:0] rx_in, ry_in;
        logic [14:0] qx_in, qy_in;
        logic [52:0] den_in;
        logic        ok_in;
        logic [67:0] dsh;
        logic        gex, gey;

        if (i == 0) begin : g_first
            assign rx_in  = numx_reg;
            assign ry_in  = numy_reg;
            assign qx_in  = '0;
            assign qy_in  = '0;
            assign den_in = den_reg;
            assign ok_in  = ok_reg;
        end else begin : g_chain
            assign rx_in  = drx_reg[i-1];
            assign ry_in  = dry_reg[i-1];
            assign qx_in  = dqx_reg[i-1];
            assign qy_in  = dqy_reg[i-1];
            assign den_in = dden_reg[i-1];
            assign ok_in  = dok_reg[i-1];
        end

        assign dsh = 68'(den_in) << B;
        assign gex = 68'(rx_in) >= dsh;
        assign gey = 68'(ry_in) >= dsh;

        always_ff @(posedge aclk) begin
            if (en) begin
                drx_reg[i]  <= gex ? 57'(68'(rx_in) - dsh) : rx_in;
                dry_reg[i]  <= gey ? 57'(68'(ry_in) - dsh) : ry_in;
                dqx_reg[i]  <= {qx_in[13:0], gex};
                dqy_reg[i]  <= {qy_in[13:0], gey};
                dden_reg[i] <= den_in;
                dok_reg[i]  <= ok_in;
            end
        end
    end

    assign m_data.source_x = dqx_reg[QW-1];
    assign m_data.source_y = dqy_reg[QW-1];
    assign m_data.in_range = dok_reg[QW-1];

    // A point out of range must come out as zero coordinates.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.in_range |-> m_data.source_x == '0 && m_data.source_y == '0)
        else $error("out-of-range transaction with nonzero coordinates");

    // The quotient must fit the 15-bit result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[29] |-> (68'(numx_reg) < (68'(den_reg) << QW)) &&
                        (68'(numy_reg) < (68'(den_reg) << QW)))
        else $error("divider input exceeds quotient range");

    // Reset empties the pipeline.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

[sim/cylinder_unwrap_coordinate_map_unit_test.sv]
`timescale 1ns / 1ps

module cylinder_unwrap_coordinate_map_unit_test;

    localparam int          CLK_HALF     = 6;
    localparam int          PIPE_DELAY   = 60;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          RANDOM_ITEMS = 1700;
    localparam int          IDLE_PCT     = 31;
    localparam logic [3:0]  CFG_UNUSED   = 4'd9;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    cuc_pkg::in_item_t   s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    cuc_pkg::out_item_t  m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [3:0]          cfg_index = '0;
    logic [63:0]         cfg_data = '0;

    // Copies of the configuration registers used by the predictor.
    logic [59:0] coef_x = '0;
    logic [59:0] coef_y = '0;
    logic [59:0] coef_depth = '0;
    logic [47:0] cam_offsets = '0;
    logic [23:0] radius = '0;
    logic [23:0] base_height = '0;
    logic [23:0] row_pitch = '0;
    logic [23:0] col_angle = '0;

    cuc_pkg::out_item_t coord_q[$];
    int                 mismatches = 0;
    int                 cycles = 0;
    bit                 no_idle = 1'b0;

    typedef struct {
        logic [11:0]        col;
        logic [11:0]        row;
        bit                 geo;
        bit                 typed;
        cuc_pkg::out_item_t exp;
    } stim_row_t;

    stim_row_t dir_tab[] = '{
        '{12'd0,    12'd0,    1'b0, 1'b1, '0},
        '{12'd4095, 12'd4095, 1'b0, 1'b1, '0},
        '{12'd4095, 12'd0,    1'b0, 1'b1, '0},
        '{12'd0,    12'd4095, 1'b0, 1'b1, '0},
        '{12'hAAA,  12'h555,  1'b0, 1'b1, '0},
        '{12'd0,    12'd0,    1'b1, 1'b0, '0},
        '{12'd0,    12'd4095, 1'b1, 1'b0, '0},
        '{12'd100,  12'd1000, 1'b1, 1'b0, '0},
        '{12'd4000, 12'd1000, 1'b1, 1'b0, '0},
        '{12'd4095, 12'd0,    1'b1, 1'b0, '0},
        '{12'd1024, 12'd500,  1'b1, 1'b0, '0},
        '{12'd2048, 12'd500,  1'b1, 1'b0, '0},
        '{12'd3072, 12'd500,  1'b1, 1'b0, '0},
        '{12'd300,  12'd2000, 1'b1, 1'b0, '0},
        '{12'd50,   12'd3500, 1'b1, 1'b0, '0},
        '{12'hAAA,  12'h555,  1'b1, 1'b0, '0},
        '{12'h555,  12'hAAA,  1'b1, 1'b0, '0}
    };

    cylinder_unwrap_coordinate_map_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    function automatic longint coef(input logic [59:0] row_bits, input int lane);
        logic [19:0] c;
        longint r;
        c = row_bits[lane*20 +: 20];
        r = $signed(c);
        return r;
    endfunction

    function automatic logic [59:0] pack_row(input int a, input int b, input int c);
        logic [19:0] fa, fb, fc;
        fa = a[19:0];
        fb = b[19:0];
        fc = c[19:0];
        return {fc, fb, fa};
    endfunction

    // Maps one unwrapped pixel to its source coordinate with the current setup.
    function automatic cuc_pkg::out_item_t map_pixel(input cuc_pkg::in_item_t px_in);
        longint unsigned sdiv[6] = '{156, 110, 72, 42, 20, 6};
        longint unsigned cdiv[6] = '{182, 132, 90, 56, 30, 12};
        longint unsigned one_q30, theta, f, x, x2, t, mag, prod;
        logic [63:0] turns;
        logic [19:0] phase;
        logic [23:0] off_a, off_b;
        longint s, c, cv, sv, px, py, pz, z, nx, ny, a1, a2;
        cuc_pkg::out_item_t res;
        res = '0;
        one_q30 = 64'd1 << 30;
        theta = longint'(px_in.dest_column) * longint'(col_angle);
        turns = theta * 64'd683565276;
        phase = turns[55:36];
        f = 64'(phase[17:0]);
        x = (f * 64'd1686629713) >> 18;
        x2 = (x * x) >> 30;
        t = one_q30;
        for (int i = 0; i < 6; i++) t = one_q30 - ((x2 * t) >> 30) / sdiv[i];
        s = longint'((x * t) >> 30);
        t = one_q30;
        for (int i = 0; i < 6; i++) t = one_q30 - ((x2 * t) >> 30) / cdiv[i];
        c = longint'(one_q30) - longint'(((x2 * t) >> 30) / 2);
        if (c < 0) c = 0;
        case (phase[19:18])
            2'd0: begin cv = c;  sv = s;  end
            2'd1: begin cv = -s; sv = c;  end
            2'd2: begin cv = -c; sv = -s; end
            default: begin cv = s; sv = -c; end
        endcase
        off_a = cam_offsets[23:0];
        off_b = cam_offsets[47:24];
        a1 = $signed(off_a);
        a2 = $signed(off_b);
        // Radius terms round half away from zero.
        mag = (cv < 0) ? longint'(-cv) : longint'(cv);
        prod = (longint'(radius) * mag + (64'd1 << 29)) >> 30;
        px = a1 + ((cv < 0) ? -longint'(prod) : longint'(prod));
        mag = (sv < 0) ? longint'(-sv) : longint'(sv);
        prod = (longint'(radius) * mag + (64'd1 << 29)) >> 30;
        py = a2 + ((sv < 0) ? -longint'(prod) : longint'(prod));
        pz = longint'(base_height)
             + longint'((longint'(px_in.dest_row) * longint'(row_pitch) + 128) >> 8);
        z  = coef(coef_depth, 0) * px + coef(coef_depth, 1) * py + coef(coef_depth, 2) * pz;
        nx = coef(coef_x, 0) * px + coef(coef_x, 1) * py + coef(coef_x, 2) * pz;
        ny = coef(coef_y, 0) * px + coef(coef_y, 1) * py + coef(coef_y, 2) * pz;
        if (z > 0 && nx >= 0 && ny >= 0 && nx <= 2047 * z && ny <= 2047 * z) begin
            res.source_x = 15'((longint'(nx) * 16) / z);
            res.source_y = 15'((longint'(ny) * 16) / z);
            res.in_range = 1'b1;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        cuc_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (coord_q.size() == 0) begin
                $display("%0t: unexpected transaction %h", $time, m_data);
                mismatches++;
            end else begin
                want = coord_q.pop_front();
                if (m_data.source_x !== want.source_x) begin
                    $display("%0t: source_x expected %0d actual %0d",
                             $time, want.source_x, m_data.source_x);
                    mismatches++;
                end
                if (m_data.source_y !== want.source_y) begin
                    $display("%0t: source_y expected %0d actual %0d",
                             $time, want.source_y, m_data.source_y);
                    mismatches++;
                end
                if (m_data.in_range !== want.in_range) begin
                    $display("%0t: in_range expected %0d actual %0d",
                             $time, want.in_range, m_data.in_range);
                    mismatches++;
                end
            end
        end
    end

    task automatic drain();
        while (coord_q.size() != 0) @(posedge aclk);
        repeat (PIPE_DELAY) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            cuc_pkg::CFG_MATRIX_ROW_X:     coef_x = val[59:0];
            cuc_pkg::CFG_MATRIX_ROW_Y:     coef_y = val[59:0];
            cuc_pkg::CFG_MATRIX_ROW_DEPTH: coef_depth = val[59:0];
            cuc_pkg::CFG_CAMERA_OFFSETS:   cam_offsets = val[47:0];
            cuc_pkg::CFG_CYLINDER_RADIUS:  radius = val[23:0];
            cuc_pkg::CFG_HEIGHT_BASE:      base_height = val[23:0];
            cuc_pkg::CFG_HEIGHT_STEP:      row_pitch = val[23:0];
            cuc_pkg::CFG_ANGLE_STEP:       col_angle = val[23:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // A camera looking along x at a unit cylinder, optionally jittered.
    task automatic setup_geometry(input bit jitter);
        int j;
        j = jitter ? 1 : 0;
        write_reg(cuc_pkg::CFG_MATRIX_ROW_X, 64'(pack_row(262144 + j * $urandom_range(40000),
                  128000 - j * $urandom_range(60000), 0)));
        write_reg(cuc_pkg::CFG_MATRIX_ROW_Y, 64'(pack_row(262144, j * $urandom_range(20000),
                  102400 - j * $urandom_range(50000))));
        write_reg(cuc_pkg::CFG_MATRIX_ROW_DEPTH, 64'(pack_row(256 + j * $urandom_range(100),
                  0, j * $urandom_range(20))));
        write_reg(cuc_pkg::CFG_CAMERA_OFFSETS, jitter ?
                  {16'h0, 24'($urandom_range(6000)), 24'($urandom_range(6000))} : 64'h0);
        write_reg(cuc_pkg::CFG_CYLINDER_RADIUS, 64'd65536 + 64'(j * $urandom_range(30000)));
        write_reg(cuc_pkg::CFG_HEIGHT_BASE, 64'h8000);
        write_reg(cuc_pkg::CFG_HEIGHT_STEP, 64'd16384 - 64'(j * $urandom_range(8000)));
        write_reg(cuc_pkg::CFG_ANGLE_STEP, 64'd25736 + 64'(j * $urandom_range(5000)));
    endtask

    task automatic setup_all(input bit ones);
        logic [63:0] v;
        for (int i = 0; i < 8; i++) begin
            v = ones ? '1 : {$urandom, $urandom};
            write_reg(cuc_pkg::cfg_index_t'(i), v);
        end
    endtask

    task automatic send_pixel(input cuc_pkg::in_item_t px_in, input bit typed,
                              input cuc_pkg::out_item_t exp);
        // Each cycle before the transaction is idle with the same chance.
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= px_in;
        do @(posedge aclk); while (!s_ready);
        coord_q.push_back(typed ? exp : map_pixel(px_in));
    endtask

    initial begin
        cuc_pkg::in_item_t px_in;
        bit geo_now;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        geo_now = 1'b0;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].geo != geo_now) begin
                s_valid <= 1'b0;
                drain();
                setup_geometry(1'b0);
                geo_now = dir_tab[i].geo;
            end
            px_in.dest_column = dir_tab[i].col;
            px_in.dest_row = dir_tab[i].row;
            send_pixel(px_in, dir_tab[i].typed, dir_tab[i].exp);
        end
        s_valid <= 1'b0;
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 250 == 0) begin
                s_valid <= 1'b0;
                drain();
                case ((n / 250) % 7)
                    0: setup_all(1'b1);
                    3: setup_all(1'b0);
                    5: begin
                        setup_geometry(1'b1);
                        // A write past the register list must change nothing.
                        write_reg(CFG_UNUSED, {$urandom, $urandom});
                    end
                    default: setup_geometry(1'b1);
                endcase
            end
            no_idle = (n >= 600 && n < 900);
            if (n == 1200) begin
                s_valid <= 1'b0;
                while (coord_q.size() != 0) @(posedge aclk);
            end
            px_in.dest_column = 12'($urandom);
            px_in.dest_row = 12'($urandom);
            send_pixel(px_in, 1'b0, '0);
        end
        s_valid <= 1'b0;
        no_idle = 1'b0;
        drain();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
